FILE: hw/rtl/mlhp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mesh layer-2 header parser.
// No dependencies; imported by every module of the block.
package mlhp_pkg;

  localparam int MAX_FRAME_BYTES_DEF = 256;
  localparam int OUT_FIFO_DEPTH      = 4;
  localparam int CFG_IDX_W           = 2;
  localparam int ID_MAX_BYTES        = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_CURRENT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ID_PREVIOUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTO_MASK      = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_LEN   = 3'd1;
  localparam logic [2:0] ST_BAD_CTRL  = 3'd2;
  localparam logic [2:0] ST_BAD_DEST  = 3'd3;
  localparam logic [2:0] ST_BAD_SRC   = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;
  localparam logic [2:0] ST_NOT_OURS  = 3'd6;
  localparam logic [2:0] ST_PROTO_OFF = 3'd7;

  localparam logic ITEM_PAYLOAD = 1'b0;
  localparam logic ITEM_VERDICT = 1'b1;

  typedef enum logic [2:0] {
    PH_CTRL1   = 3'd0,
    PH_CTRL2   = 3'd1,
    PH_DEST    = 3'd2,
    PH_SRC     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DRAIN   = 3'd5
  } phase_t;

  typedef struct packed {
    logic        item_kind;
    logic [7:0]  payload_byte;
    logic [2:0]  status;
    logic        is_broadcast;
    logic [2:0]  security_mode;
    logic [3:0]  protocol;
    logic [31:0] dest_id;
    logic [31:0] source_id;
    logic [8:0]  payload_count;
    logic        last_of_frame;
  } result_t;

  typedef struct packed {
    logic    val_a;
    logic    val_b;
    result_t res_a;
    result_t res_b;
  } push_t;

endpackage

FILE: hw/rtl/mlhp_parser.sv
`timescale 1ns / 1ps
// Per-byte frame parser: control field, IDs, held payload byte and verdict.
// Depends on mlhp_pkg; feeds up to two result items per byte to the output queue.
module mlhp_parser import mlhp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        take,
  input  logic [7:0]  rx_byte,
  input  logic        frame_end,
  input  logic [31:0] own_id_current,
  input  logic [31:0] own_id_previous,
  input  logic [15:0] protocol_enable_mask,
  output push_t       push
);

  localparam int FLEN_W = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [FLEN_W-1:0] FLEN_MAX = FLEN_W'(MAX_FRAME_BYTES);
  localparam logic [FLEN_W-1:0] FLEN_MIN = FLEN_W'(2);

  phase_t             phase_r, phase_nxt;
  logic [FLEN_W-1:0]  flen_r, flen_nxt;
  logic [31:0]        acc_r, acc_nxt;
  logic [2:0]         cnt_r, cnt_nxt;
  logic [31:0]        dest_r, dest_nxt;
  logic [31:0]        src_r, src_nxt;
  logic [7:0]         ctrl_r, ctrl_nxt;
  logic [2:0]         err_r, err_nxt;
  logic [7:0]         held_r, held_nxt;
  logic               held_vld_r, held_vld_nxt;
  logic [8:0]         pcnt_r, pcnt_nxt;

  logic               in_range;
  logic [31:0]        acc_shift;
  logic [2:0]         cnt_inc;
  logic               id_full;
  logic [8:0]         vcount;
  logic [2:0]         vstatus;
  logic               dest_ok;
  result_t            verdict;
  result_t            pay_res;

  assign in_range  = flen_r < FLEN_MAX;
  assign acc_shift = {acc_r[24:0], rx_byte[6:0]};
  assign cnt_inc   = cnt_r + 3'd1;
  assign id_full   = cnt_inc >= 3'(ID_MAX_BYTES);
  assign vcount    = pcnt_r + 9'(held_vld_r);
  assign dest_ok   = (dest_r != 32'd0) &&
                     ((dest_r == own_id_current) || (dest_r == own_id_previous));

  always_comb begin
    priority if ((flen_r < FLEN_MIN) || (flen_r > FLEN_MAX)) begin
      vstatus = ST_BAD_LEN;
    end else if (err_r != ST_OK) begin
      vstatus = err_r;
    end else if ((phase_r == PH_CTRL1) || (phase_r == PH_CTRL2)) begin
      vstatus = ST_BAD_CTRL;
    end else if (phase_r == PH_DEST) begin
      vstatus = ST_BAD_DEST;
    end else if (phase_r == PH_SRC) begin
      vstatus = ST_BAD_SRC;
    end else if (vcount == 9'd0) begin
      vstatus = ST_EMPTY;
    end else if (!ctrl_r[7] && !dest_ok) begin
      vstatus = ST_NOT_OURS;
    end else if (!protocol_enable_mask[ctrl_r[3:0]]) begin
      vstatus = ST_PROTO_OFF;
    end else begin
      vstatus = ST_OK;
    end
  end

  always_comb begin
    verdict               = '0;
    verdict.item_kind     = ITEM_VERDICT;
    verdict.status        = vstatus;
    verdict.is_broadcast  = ctrl_r[7];
    verdict.security_mode = ctrl_r[6:4];
    verdict.protocol      = ctrl_r[3:0];
    verdict.dest_id       = ctrl_r[7] ? 32'd0 : dest_r;
    verdict.source_id     = src_r;
    verdict.payload_count = vcount;
    verdict.last_of_frame = 1'b1;
    pay_res               = '0;
    pay_res.item_kind     = ITEM_PAYLOAD;
    pay_res.payload_byte  = held_r;
  end

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      if (frame_end) begin
        phase_nxt = PH_CTRL1;
      end else if (in_range) begin
        unique case (phase_r)
          PH_CTRL1: phase_nxt = rx_byte[7] ? PH_CTRL2 : (rx_byte[6] ? PH_SRC : PH_DEST);
          PH_CTRL2: phase_nxt = rx_byte[7] ? PH_DRAIN : (ctrl_r[7] ? PH_SRC : PH_DEST);
          PH_DEST:  phase_nxt = !rx_byte[7] ? PH_SRC : (id_full ? PH_DRAIN : PH_DEST);
          PH_SRC:   phase_nxt = !rx_byte[7] ? PH_PAYLOAD : (id_full ? PH_DRAIN : PH_SRC);
          default:  phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Datapath and result items
  always_comb begin
    flen_nxt     = flen_r;
    acc_nxt      = acc_r;
    cnt_nxt      = cnt_r;
    dest_nxt     = dest_r;
    src_nxt      = src_r;
    ctrl_nxt     = ctrl_r;
    err_nxt      = err_r;
    held_nxt     = held_r;
    held_vld_nxt = held_vld_r;
    pcnt_nxt     = pcnt_r;
    push         = '0;
    if (take) begin
      if (frame_end) begin
        if (held_vld_r) begin
          push.val_a = 1'b1;
          push.res_a = pay_res;
          push.val_b = 1'b1;
          push.res_b = verdict;
        end else begin
          push.val_a = 1'b1;
          push.res_a = verdict;
        end
        flen_nxt     = '0;
        acc_nxt      = '0;
        cnt_nxt      = '0;
        dest_nxt     = '0;
        src_nxt      = '0;
        ctrl_nxt     = '0;
        err_nxt      = ST_OK;
        held_nxt     = '0;
        held_vld_nxt = 1'b0;
        pcnt_nxt     = '0;
      end else begin
        if (flen_r <= FLEN_MAX) begin
          flen_nxt = flen_r + FLEN_W'(1);
        end
        if (in_range) begin
          unique case (phase_r)
            PH_CTRL1: begin
              ctrl_nxt = {rx_byte[6], 1'b0, rx_byte[5:4], 2'b00, rx_byte[3:2]};
            end
            PH_CTRL2: begin
              ctrl_nxt = {ctrl_r[7], ctrl_r[6] ^ rx_byte[6], ctrl_r[5:4],
                          ctrl_r[1:0], rx_byte[1:0]};
              if (rx_byte[7]) begin
                err_nxt = ST_BAD_CTRL;
              end
            end
            PH_DEST, PH_SRC: begin
              acc_nxt = acc_shift;
              cnt_nxt = cnt_inc;
              if (!rx_byte[7]) begin
                if (phase_r == PH_DEST) begin
                  dest_nxt = acc_shift;
                end else begin
                  src_nxt = acc_shift;
                end
                acc_nxt = '0;
                cnt_nxt = '0;
              end else if (id_full) begin
                err_nxt = (phase_r == PH_DEST) ? ST_BAD_DEST : ST_BAD_SRC;
              end
            end
            PH_PAYLOAD: begin
              if (held_vld_r) begin
                push.val_a = 1'b1;
                push.res_a = pay_res;
                pcnt_nxt   = pcnt_r + 9'd1;
              end
              held_nxt     = rx_byte;
              held_vld_nxt = 1'b1;
            end
            default: begin
              held_nxt = held_r;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CTRL1;
      flen_r     <= '0;
      acc_r      <= '0;
      cnt_r      <= '0;
      dest_r     <= '0;
      src_r      <= '0;
      ctrl_r     <= '0;
      err_r      <= ST_OK;
      held_r     <= '0;
      held_vld_r <= 1'b0;
      pcnt_r     <= '0;
    end else begin
      phase_r    <= phase_nxt;
      flen_r     <= flen_nxt;
      acc_r      <= acc_nxt;
      cnt_r      <= cnt_nxt;
      dest_r     <= dest_nxt;
      src_r      <= src_nxt;
      ctrl_r     <= ctrl_nxt;
      err_r      <= err_nxt;
      held_r     <= held_nxt;
      held_vld_r <= held_vld_nxt;
      pcnt_r     <= pcnt_nxt;
    end
  end

endmodule

FILE: hw/rtl/mlhp_out_fifo.sv
`timescale 1ns / 1ps
// Small result queue: takes up to two items per cycle, gives one per cycle on pop.
// Depends on mlhp_pkg for result_t and push_t.
module mlhp_out_fifo import mlhp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  input  logic    pop,
  output result_t head,
  output logic    not_empty,
  output logic    room2
);

  localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(OUT_FIFO_DEPTH + 1);

  result_t            mem [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [PTR_W-1:0]   wr_ptr_b;

  assign wr_ptr_b   = wr_ptr_r + PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + PTR_W'(push.val_a) + PTR_W'(push.val_b);
  assign rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
  assign count_nxt  = count_r + CNT_W'(push.val_a) + CNT_W'(push.val_b) - CNT_W'(pop);
  assign head       = mem[rd_ptr_r];
  assign not_empty  = count_r != '0;
  assign room2      = count_r <= CNT_W'(OUT_FIFO_DEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.val_a) begin
      mem[wr_ptr_r] <= push.res_a;
    end
    if (push.val_b) begin
      mem[wr_ptr_b] <= push.res_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

FILE: hw/rtl/mesh_l2_header_parser_top.sv
`timescale 1ns / 1ps
// Mesh layer-2 receive header parser, top level with configuration registers.
// Depends on mlhp_pkg, mlhp_parser and mlhp_out_fifo.
//
// Takes one frame byte per cycle while in_ready is high. Each byte is parsed
// in the cycle it is accepted and its result items enter a four-entry output
// queue, so a result can be taken in the cycle after its byte. Payload bytes
// leave one byte late; the frame-end beat (its byte is not parsed) yields the
// held payload byte (if any) and the verdict in the same cycle. The queue
// drains one item per cycle while out_ready is high, and the input is ready
// while the queue has at least two free entries, so the block sustains one
// byte per cycle when the output side also takes one item per cycle.
// Configuration writes are taken in any cycle.
module mesh_l2_header_parser_top import mlhp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_rx_byte,
  input  logic                 in_frame_end,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_item_kind,
  output logic [7:0]           out_payload_byte,
  output logic [2:0]           out_status,
  output logic                 out_is_broadcast,
  output logic [2:0]           out_security_mode,
  output logic [3:0]           out_protocol,
  output logic [31:0]          out_dest_id,
  output logic [31:0]          out_source_id,
  output logic [8:0]           out_payload_count,
  output logic                 out_last_of_frame,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [31:0] own_cur_r;
  logic [31:0] own_prev_r;
  logic [15:0] proto_mask_r;
  logic        take;
  logic        pop;
  logic        room2;
  push_t       push;
  result_t     head;

  assign cfg_ready = 1'b1;
  assign take      = in_valid & in_ready;
  assign in_ready  = room2;
  assign pop       = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_cur_r    <= '0;
      own_prev_r   <= '0;
      proto_mask_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_OWN_ID_CURRENT:  own_cur_r    <= cfg_data;
        CFG_OWN_ID_PREVIOUS: own_prev_r   <= cfg_data;
        CFG_PROTO_MASK:      proto_mask_r <= cfg_data[15:0];
        default:             proto_mask_r <= proto_mask_r;
      endcase
    end
  end

  mlhp_parser #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parser (
    .clk                 (clk),
    .rst_n               (rst_n),
    .take                (take),
    .rx_byte             (in_rx_byte),
    .frame_end           (in_frame_end),
    .own_id_current      (own_cur_r),
    .own_id_previous     (own_prev_r),
    .protocol_enable_mask(proto_mask_r),
    .push                (push)
  );

  mlhp_out_fifo u_out_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .pop      (pop),
    .head     (head),
    .not_empty(out_valid),
    .room2    (room2)
  );

  assign out_item_kind     = head.item_kind;
  assign out_payload_byte  = head.payload_byte;
  assign out_status        = head.status;
  assign out_is_broadcast  = head.is_broadcast;
  assign out_security_mode = head.security_mode;
  assign out_protocol      = head.protocol;
  assign out_dest_id       = head.dest_id;
  assign out_source_id     = head.source_id;
  assign out_payload_count = head.payload_count;
  assign out_last_of_frame = head.last_of_frame;

  a_end_gives_item: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_frame_end) |=> out_valid)
    else $error("frame end accepted but no result queued");

  a_verdict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item_kind == out_last_of_frame))
    else $error("last_of_frame does not match verdict item");

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item_kind == ITEM_PAYLOAD)) |->
      ((out_status == ST_OK) && (out_payload_count == 9'd0)))
    else $error("payload item carries verdict fields");

  a_bcast_dest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_item_kind == ITEM_VERDICT) && out_is_broadcast) |->
      (out_dest_id == 32'd0))
    else $error("broadcast verdict with nonzero destination");

endmodule
